// File: rtl/lst_pkg.sv
package lst_pkg;

    localparam int FUNC_W   = 3;
    localparam int POS_W    = 10;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 2;

    localparam logic [FUNC_W-1:0] FN_APPEND = 3'd0;
    localparam logic [FUNC_W-1:0] FN_POP    = 3'd1;
    localparam logic [FUNC_W-1:0] FN_READ   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_WRITE  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_INSERT = 3'd4;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic load;
        logic mem_rd;
        logic rd_last;
        logic mem_wr;
        logic wr_tail;
        logic shift_init;
        logic shift_step;
        logic take_dout;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              err;
        logic              left_zero;
        logic              pend;
        logic              out_free;
    } t_sts;

endpackage

// File: rtl/lst_ctrl.sv
module lst_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  lst_pkg::t_sts   i_sts,
    output logic            o_in_ready,
    output lst_pkg::t_cmd   o_cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DECIDE  = 3'd1;
    localparam logic [2:0] S_WAIT_RD = 3'd2;
    localparam logic [2:0] S_SHIFT   = 3'd3;
    localparam logic [2:0] S_FINISH  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.err) begin
                    n_state = S_FINISH;
                end else begin
                    case (i_sts.func)
                        lst_pkg::FN_APPEND: begin
                            o_cmd.mem_wr  = 1'b1;
                            o_cmd.wr_tail = 1'b1;
                            n_state       = S_FINISH;
                        end
                        lst_pkg::FN_WRITE: begin
                            o_cmd.mem_wr = 1'b1;
                            n_state      = S_FINISH;
                        end
                        lst_pkg::FN_POP: begin
                            o_cmd.mem_rd  = 1'b1;
                            o_cmd.rd_last = 1'b1;
                            n_state       = S_WAIT_RD;
                        end
                        lst_pkg::FN_READ: begin
                            o_cmd.mem_rd = 1'b1;
                            n_state      = S_WAIT_RD;
                        end
                        lst_pkg::FN_REMOVE: begin
                            o_cmd.mem_rd     = 1'b1;
                            o_cmd.shift_init = 1'b1;
                            n_state          = S_WAIT_RD;
                        end
                        lst_pkg::FN_INSERT: begin
                            o_cmd.shift_init = 1'b1;
                            n_state          = S_SHIFT;
                        end
                        default: begin
                            n_state = S_FINISH;
                        end
                    endcase
                end
            end
            S_WAIT_RD: begin
                o_cmd.take_dout = 1'b1;
                if (i_sts.func == lst_pkg::FN_REMOVE) begin
                    n_state = S_SHIFT;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_SHIFT: begin
                if (!i_sts.left_zero) begin
                    o_cmd.shift_step = 1'b1;
                end else if (!i_sts.pend) begin
                    if (i_sts.func == lst_pkg::FN_INSERT) begin
                        o_cmd.mem_wr = 1'b1;
                    end
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/lst_dpath.sv
module lst_dpath #(
    parameter int DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  lst_pkg::t_cmd                          i_cmd,
    output lst_pkg::t_sts                          o_sts,
    input  logic        [lst_pkg::FUNC_W-1:0]      i_func,
    input  logic        [lst_pkg::POS_W-1:0]       i_position,
    input  logic signed [lst_pkg::DATA_W-1:0]      i_data_in,
    input  logic                                   i_out_ready,
    output logic                                   o_out_valid,
    output logic signed [lst_pkg::DATA_W-1:0]      o_data_out,
    output logic        [lst_pkg::COUNT_W-1:0]     o_count_after,
    output logic        [lst_pkg::STATUS_W-1:0]    o_status
);

    localparam int AW      = $clog2(DEPTH);
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int XW      = (CW > lst_pkg::POS_W) ? CW : lst_pkg::POS_W;
    localparam int CntOutW = lst_pkg::COUNT_W;

    logic        [lst_pkg::FUNC_W-1:0]   r_func;
    logic        [lst_pkg::POS_W-1:0]    r_pos;
    logic signed [lst_pkg::DATA_W-1:0]   r_din;
    logic        [CW-1:0]                r_cnt;
    logic signed [lst_pkg::DATA_W-1:0]   r_mem [DEPTH];
    logic signed [lst_pkg::DATA_W-1:0]   r_rd_data;
    logic signed [lst_pkg::DATA_W-1:0]   r_dout;
    logic        [AW-1:0]                r_src;
    logic        [AW-1:0]                r_dst;
    logic        [CW-1:0]                r_left;
    logic                                r_pend;
    logic                                r_out_valid;
    logic signed [lst_pkg::DATA_W-1:0]   r_data_out;
    logic        [lst_pkg::STATUS_W-1:0] r_status;

    logic        [XW-1:0]                cnt_x;
    logic        [XW-1:0]                pos_x;
    logic                                full;
    logic                                empty;
    logic        [lst_pkg::STATUS_W-1:0] status;
    logic                                ok;
    logic                                is_insert;
    logic                                gives_data;
    logic                                rd_en;
    logic        [AW-1:0]                rd_addr;
    logic                                wr_en;
    logic        [AW-1:0]                wr_addr;
    logic signed [lst_pkg::DATA_W-1:0]   wr_data;

    assign cnt_x      = XW'(r_cnt);
    assign pos_x      = XW'(r_pos);
    assign full       = (r_cnt == CW'(DEPTH));
    assign empty      = (r_cnt == '0);
    assign is_insert  = (r_func == lst_pkg::FN_INSERT);
    assign gives_data = (r_func == lst_pkg::FN_POP) || (r_func == lst_pkg::FN_READ)
                        || (r_func == lst_pkg::FN_REMOVE);

    always_comb begin
        status = lst_pkg::ST_OK;
        case (r_func)
            lst_pkg::FN_APPEND: begin
                if (full) begin
                    status = lst_pkg::ST_FULL;
                end
            end
            lst_pkg::FN_POP: begin
                if (empty) begin
                    status = lst_pkg::ST_EMPTY;
                end
            end
            lst_pkg::FN_READ, lst_pkg::FN_WRITE, lst_pkg::FN_REMOVE: begin
                if (empty) begin
                    status = lst_pkg::ST_EMPTY;
                end else if (pos_x >= cnt_x) begin
                    status = lst_pkg::ST_RANGE;
                end
            end
            lst_pkg::FN_INSERT: begin
                if (full) begin
                    status = lst_pkg::ST_FULL;
                end else if (pos_x > cnt_x) begin
                    status = lst_pkg::ST_RANGE;
                end
            end
            default: begin
                status = lst_pkg::ST_OK;
            end
        endcase
    end

    assign ok = (status == lst_pkg::ST_OK);

    assign rd_en   = i_cmd.mem_rd || i_cmd.shift_step;
    assign rd_addr = i_cmd.shift_step ? r_src
                   : (i_cmd.rd_last ? AW'(r_cnt - 1'b1) : AW'(r_pos));
    assign wr_en   = r_pend || i_cmd.mem_wr;
    assign wr_addr = r_pend ? r_dst : (i_cmd.wr_tail ? AW'(r_cnt) : AW'(r_pos));
    assign wr_data = r_pend ? r_rd_data : r_din;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_pos  <= i_position;
            r_din  <= i_data_in;
        end
        if (i_cmd.take_dout) begin
            r_dout <= r_rd_data;
        end
        if (i_cmd.shift_init) begin
            if (is_insert) begin
                r_src  <= AW'(r_cnt - 1'b1);
                r_left <= CW'(cnt_x - pos_x);
            end else begin
                r_src  <= AW'(pos_x + 1'b1);
                r_left <= CW'(cnt_x - pos_x - 1'b1);
            end
        end else if (i_cmd.shift_step) begin
            r_left <= r_left - 1'b1;
            if (is_insert) begin
                r_dst <= r_src + 1'b1;
                r_src <= r_src - 1'b1;
            end else begin
                r_dst <= r_src - 1'b1;
                r_src <= r_src + 1'b1;
            end
        end
        if (i_cmd.commit) begin
            r_status   <= status;
            r_data_out <= (ok && gives_data) ? r_dout : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= i_cmd.shift_step;
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
                if (ok) begin
                    case (r_func)
                        lst_pkg::FN_APPEND, lst_pkg::FN_INSERT: begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                        lst_pkg::FN_POP, lst_pkg::FN_REMOVE: begin
                            r_cnt <= r_cnt - 1'b1;
                        end
                        default: begin
                            r_cnt <= r_cnt;
                        end
                    endcase
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.func      = r_func;
    assign o_sts.err       = !ok;
    assign o_sts.left_zero = (r_left == '0);
    assign o_sts.pend      = r_pend;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_data_out    = r_data_out;
    assign o_count_after = CntOutW'(r_cnt);
    assign o_status      = r_status;

endmodule

// File: rtl/indexed_list_store_core.sv
// Channel   Handshake                 Payload
// request   i_in_valid / o_in_ready   i_func, i_position, i_data_in
// result    o_out_valid / i_out_ready o_data_out, o_count_after, o_status
//
// One item is worked at a time. Append, overwrite, unused codes and failed items are loaded,
// decided and committed; read and pop also wait for the memory read data before commit.
// Insert and remove move one entry per cycle through the memory's read and write ports;
// remove reads its entry before the moves, and insert writes its value after them.
// Reset clears the entry count and the control state; the entries themselves are not cleared.
// A result waits in the output register while the next item is accepted and worked; a
// stalled result holds that item in its last cycle until the register is free.
module indexed_list_store_core #(
    parameter int DEPTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic        [lst_pkg::FUNC_W-1:0]   i_func,
    input  logic        [lst_pkg::POS_W-1:0]    i_position,
    input  logic signed [lst_pkg::DATA_W-1:0]   i_data_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [lst_pkg::DATA_W-1:0]   o_data_out,
    output logic        [lst_pkg::COUNT_W-1:0]  o_count_after,
    output logic        [lst_pkg::STATUS_W-1:0] o_status
);

    lst_pkg::t_cmd cmd;
    lst_pkg::t_sts sts;

    lst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    lst_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_func        (i_func),
        .i_position    (i_position),
        .i_data_in     (i_data_in),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_data_out    (o_data_out),
        .o_count_after (o_count_after),
        .o_status      (o_status)
    );

endmodule

// File: rtl/lst_checker.sv
module lst_checker #(
    parameter int DEPTH = 1024
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_ready,
    input logic        [lst_pkg::FUNC_W-1:0]   i_func,
    input logic        [lst_pkg::POS_W-1:0]    i_position,
    input logic signed [lst_pkg::DATA_W-1:0]   i_data_in,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic signed [lst_pkg::DATA_W-1:0]   o_data_out,
    input logic        [lst_pkg::COUNT_W-1:0]  o_count_after,
    input logic        [lst_pkg::STATUS_W-1:0] o_status
);

    localparam int CntOutW = lst_pkg::COUNT_W;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_data_out)
            && $stable(o_count_after) && $stable(o_status))
        else $error("Result item changed while stalled.");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("A second item was taken while one is in work.");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == lst_pkg::ST_FULL |-> o_count_after == CntOutW'(DEPTH))
        else $error("Full status with a count below capacity.");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == lst_pkg::ST_EMPTY |-> o_count_after == '0)
        else $error("Empty status with a nonzero count.");

    a_data_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_data_out != '0 |-> o_status == lst_pkg::ST_OK)
        else $error("Failed item returned nonzero data.");

endmodule

bind indexed_list_store_core lst_checker #(
    .DEPTH (DEPTH)
) u_lst_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_func        (i_func),
    .i_position    (i_position),
    .i_data_in     (i_data_in),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_data_out    (o_data_out),
    .o_count_after (o_count_after),
    .o_status      (o_status)
);

// File: verif/tb_indexed_list_store_core.sv
`timescale 1ns / 1ps

module tb_indexed_list_store_core;

    localparam int LIST_DEPTH = 1024;
    localparam int RANDOM_ITEMS = 460;
    localparam int SHIFT_FILL = 48;
    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 100;
    localparam logic [lst_pkg::FUNC_W-1:0] FN_SPARE_LO = 3'd6;
    localparam logic [lst_pkg::FUNC_W-1:0] FN_SPARE_HI = 3'd7;
    localparam logic signed [lst_pkg::DATA_W-1:0] DATA_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [lst_pkg::DATA_W-1:0] DATA_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [lst_pkg::DATA_W-1:0] data;
        logic [lst_pkg::COUNT_W-1:0]       count;
        logic [lst_pkg::STATUS_W-1:0]      status;
    } t_list_result;

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 i_in_valid;
    logic                                 o_in_ready;
    logic [lst_pkg::FUNC_W-1:0]           i_func;
    logic [lst_pkg::POS_W-1:0]            i_position;
    logic signed [lst_pkg::DATA_W-1:0]    i_data_in;
    logic                                 o_out_valid;
    logic                                 i_out_ready;
    logic signed [lst_pkg::DATA_W-1:0]    o_data_out;
    logic [lst_pkg::COUNT_W-1:0]          o_count_after;
    logic [lst_pkg::STATUS_W-1:0]         o_status;

    logic signed [lst_pkg::DATA_W-1:0] list_words [LIST_DEPTH];
    int                                list_len;
    t_list_result                      pending_list_results [$];
    int                                error_count;
    bit                                idle_on;

    indexed_list_store_core #(
        .DEPTH(LIST_DEPTH)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_position    (i_position),
        .i_data_in     (i_data_in),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_data_out    (o_data_out),
        .o_count_after (o_count_after),
        .o_status      (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #10 i_clk = ~i_clk;
        end
    end

    function automatic int pick_stall_len();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_send_gap();
        if (!idle_on || $urandom_range(0, 99) < 60) begin
            return 0;
        end
        return pick_stall_len();
    endfunction

    function automatic logic signed [lst_pkg::DATA_W-1:0] pick_data();
        case ($urandom_range(0, 15))
            0: return DATA_MAX;
            1: return DATA_MIN;
            2: return '0;
            3: return -1;
            default: return $urandom();
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    // Applies one accepted request to the shadow list and queues the result it must produce.
    task automatic apply_list_op(input logic [lst_pkg::FUNC_W-1:0] fn,
                                 input logic [lst_pkg::POS_W-1:0] pos,
                                 input logic signed [lst_pkg::DATA_W-1:0] din);
        t_list_result res;
        int at;
        int idx;
        at = int'(pos);
        res.data = '0;
        res.status = lst_pkg::ST_OK;
        case (fn)
            lst_pkg::FN_APPEND: begin
                if (list_len >= LIST_DEPTH) begin
                    res.status = lst_pkg::ST_FULL;
                end else begin
                    list_words[list_len] = din;
                    list_len++;
                end
            end
            lst_pkg::FN_POP: begin
                if (list_len == 0) begin
                    res.status = lst_pkg::ST_EMPTY;
                end else begin
                    list_len--;
                    res.data = list_words[list_len];
                end
            end
            lst_pkg::FN_READ, lst_pkg::FN_WRITE: begin
                if (list_len == 0) begin
                    res.status = lst_pkg::ST_EMPTY;
                end else if (at >= list_len) begin
                    res.status = lst_pkg::ST_RANGE;
                end else if (fn == lst_pkg::FN_READ) begin
                    res.data = list_words[at];
                end else begin
                    list_words[at] = din;
                end
            end
            lst_pkg::FN_INSERT: begin
                if (list_len >= LIST_DEPTH) begin
                    res.status = lst_pkg::ST_FULL;
                end else if (at > list_len) begin
                    res.status = lst_pkg::ST_RANGE;
                end else begin
                    for (idx = list_len; idx > at; idx--) begin
                        list_words[idx] = list_words[idx-1];
                    end
                    list_words[at] = din;
                    list_len++;
                end
            end
            lst_pkg::FN_REMOVE: begin
                if (list_len == 0) begin
                    res.status = lst_pkg::ST_EMPTY;
                end else if (at >= list_len) begin
                    res.status = lst_pkg::ST_RANGE;
                end else begin
                    res.data = list_words[at];
                    for (idx = at; idx + 1 < list_len; idx++) begin
                        list_words[idx] = list_words[idx+1];
                    end
                    list_len--;
                end
            end
            default: begin
            end
        endcase
        res.count = list_len[lst_pkg::COUNT_W-1:0];
        pending_list_results.push_back(res);
    endtask

    task automatic send_item(input logic [lst_pkg::FUNC_W-1:0] fn, input int pos,
                             input logic signed [lst_pkg::DATA_W-1:0] din);
        int gap;
        gap = pick_send_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func <= fn;
        i_position <= pos[lst_pkg::POS_W-1:0];
        i_data_in <= din;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        apply_list_op(fn, pos[lst_pkg::POS_W-1:0], din);
    endtask

    task automatic check_result();
        t_list_result want;
        if (pending_list_results.size() == 0) begin
            report_mismatch("result item arrived with no request outstanding");
        end else begin
            want = pending_list_results.pop_front();
            if (o_data_out !== want.data) begin
                report_mismatch($sformatf("data_out %0d, expected %0d", o_data_out, want.data));
            end
            if (o_count_after !== want.count) begin
                report_mismatch($sformatf("count_after %0d, expected %0d",
                                          o_count_after, want.count));
            end
            if (o_status !== want.status) begin
                report_mismatch($sformatf("status %0d, expected %0d", o_status, want.status));
            end
        end
    endtask

    initial begin : result_side
        int stall;
        stall = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                stall--;
            end else begin
                i_out_ready <= 1'b1;
                if (idle_on && $urandom_range(0, 99) < 20) begin
                    stall = pick_stall_len();
                end
            end
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                check_result();
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("FAIL");
        $finish;
    end

    task automatic test_empty_list();
        send_item(lst_pkg::FN_POP, 0, '0);
        send_item(lst_pkg::FN_READ, 0, '0);
        send_item(lst_pkg::FN_WRITE, 0, DATA_MAX);
        send_item(lst_pkg::FN_REMOVE, 0, '0);
        send_item(lst_pkg::FN_INSERT, 1, DATA_MAX);
        send_item(FN_SPARE_LO, 0, -1);
        send_item(FN_SPARE_HI, 1023, DATA_MIN);
    endtask

    task automatic test_each_operation();
        send_item(lst_pkg::FN_APPEND, 1023, DATA_MIN);
        send_item(lst_pkg::FN_APPEND, 0, DATA_MAX);
        send_item(lst_pkg::FN_APPEND, 0, -1);
        send_item(lst_pkg::FN_READ, 0, '0);
        send_item(lst_pkg::FN_READ, 2, '0);
        send_item(lst_pkg::FN_WRITE, 1, 32'sh1234_5678);
        send_item(lst_pkg::FN_INSERT, 0, 32'sh0000_0011);
        // Inserting at the last index puts the value before the old last entry.
        send_item(lst_pkg::FN_INSERT, 3, 32'sh0000_0022);
        // Inserting at the count places the value at the end.
        send_item(lst_pkg::FN_INSERT, 5, 32'sh0000_0033);
        send_item(lst_pkg::FN_INSERT, 7, '0);
        send_item(lst_pkg::FN_READ, 6, '0);
        send_item(lst_pkg::FN_WRITE, 6, DATA_MAX);
        send_item(lst_pkg::FN_REMOVE, 6, '0);
        send_item(lst_pkg::FN_REMOVE, 2, '0);
        send_item(lst_pkg::FN_REMOVE, 4, '0);
        send_item(lst_pkg::FN_READ, 1023, '0);
        send_item(lst_pkg::FN_POP, 1023, '0);
        send_item(FN_SPARE_HI, 0, '0);
    endtask

    task automatic test_long_shifts();
        while (list_len < SHIFT_FILL) begin
            send_item(lst_pkg::FN_APPEND, $urandom_range(0, 1023), pick_data());
        end
        send_item(lst_pkg::FN_INSERT, 0, DATA_MAX);
        send_item(lst_pkg::FN_INSERT, list_len - 1, DATA_MIN);
        send_item(lst_pkg::FN_READ, 0, '0);
        send_item(lst_pkg::FN_READ, list_len - 1, '0);
        send_item(lst_pkg::FN_REMOVE, 0, '0);
        send_item(lst_pkg::FN_REMOVE, list_len - 1, '0);
        send_item(lst_pkg::FN_INSERT, list_len, -1);
        send_item(lst_pkg::FN_REMOVE, 1, '0);
        send_item(lst_pkg::FN_READ, list_len, '0);
        send_item(lst_pkg::FN_POP, 0, '0);
        while (list_len > 8) begin
            send_item(lst_pkg::FN_POP, $urandom_range(0, 1023), $urandom());
        end
    endtask

    task automatic test_random_traffic();
        logic [lst_pkg::FUNC_W-1:0] fn;
        int pos;
        int draw;
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 40 == 0) begin
                idle_on = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 99) < 3) begin
                draw = $urandom_range(FN_SPARE_LO, FN_SPARE_HI);
            end else begin
                draw = $urandom_range(lst_pkg::FN_APPEND, lst_pkg::FN_REMOVE);
            end
            fn = draw[lst_pkg::FUNC_W-1:0];
            if (list_len > 96 && (fn == lst_pkg::FN_APPEND || fn == lst_pkg::FN_INSERT)
                    && $urandom_range(0, 1)) begin
                fn = $urandom_range(0, 1) ? lst_pkg::FN_POP : lst_pkg::FN_REMOVE;
            end
            if (list_len > 0 && $urandom_range(0, 9) < 8) begin
                pos = $urandom_range(0, (fn == lst_pkg::FN_INSERT) ? list_len : list_len - 1);
            end else begin
                pos = $urandom_range(0, 1023);
            end
            send_item(fn, pos, pick_data());
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_func = lst_pkg::FN_APPEND;
        i_position = '0;
        i_data_in = '0;
        list_len = 0;
        error_count = 0;
        idle_on = 1'b1;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_list();
        test_each_operation();
        test_long_shifts();
        test_random_traffic();

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_list_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
